// ----- rtl/core/tscan_pkg.sv -----
// Shared types and constants for the token scanner.
package tscan_pkg;

  localparam int START_W  = 20;
  localparam int LEN_W    = 21;
  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = 2;
  localparam int RQ_CW    = 3;

  typedef enum logic [4:0] {
    K_EOF     = 5'd0,
    K_LPAREN  = 5'd1,
    K_LBRACE  = 5'd2,
    K_LBRACK  = 5'd3,
    K_RPAREN  = 5'd4,
    K_RBRACE  = 5'd5,
    K_RBRACK  = 5'd6,
    K_DOT     = 5'd7,
    K_COMMA   = 5'd8,
    K_COLON   = 5'd9,
    K_SEMI    = 5'd10,
    K_EQUAL   = 5'd11,
    K_AT      = 5'd12,
    K_HASH    = 5'd13,
    K_ARROW   = 5'd14,
    K_BINOP   = 5'd15,
    K_COMMENT = 5'd16,
    K_IDENT   = 5'd17,
    K_FUNC    = 5'd18,
    K_VAR     = 5'd19,
    K_INTEGER = 5'd20,
    K_WARN    = 5'd21
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   length;
    logic               last;
  } res_t;

  // Results produced by one accepted request: cnt is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

// ----- rtl/core/tscan_if.sv -----
// Request and token channel interfaces.
interface tscan_in_if import tscan_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] byte_req;
  logic       end_of_buffer;

  modport source (output valid, byte_req, end_of_buffer, input ready);
  modport sink (input valid, byte_req, end_of_buffer, output ready);
endinterface

interface tscan_out_if import tscan_pkg::*; ();
  logic               valid;
  logic               ready;
  kind_t              token_kind;
  logic [START_W-1:0] token_start;
  logic [LEN_W-1:0]   token_length;
  logic               last_of_run;

  modport source (output valid, token_kind, token_start, token_length, last_of_run,
                  input ready);
  modport sink (input valid, token_kind, token_start, token_length, last_of_run,
                output ready);
endinterface

// ----- rtl/core/tscan_lex.sv -----
// Scanner state and per-byte classification; produces up to two tokens per request.
module tscan_lex import tscan_pkg::*; #(
  parameter int OFFSET_BITS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        acc,
  input  logic [7:0]  byte_req,
  input  logic        end_of_buffer,
  output push_t       push
);

  typedef enum logic [5:0] {
    MODE_IDLE    = 6'b000001,
    MODE_IDENT   = 6'b000010,
    MODE_NUMBER  = 6'b000100,
    MODE_MINUS   = 6'b001000,
    MODE_SLASH   = 6'b010000,
    MODE_COMMENT = 6'b100000
  } mode_t;

  localparam logic [2:0] KW_NONE = 3'd0;
  localparam logic [2:0] KW_F    = 3'd1;
  localparam logic [2:0] KW_FU   = 3'd2;
  localparam logic [2:0] KW_FUN  = 3'd3;
  localparam logic [2:0] KW_FUNC = 3'd4;
  localparam logic [2:0] KW_V    = 3'd5;
  localparam logic [2:0] KW_VA   = 3'd6;
  localparam logic [2:0] KW_VAR  = 3'd7;

  function automatic logic [2:0] kw_next(input logic [2:0] p, input logic [7:0] c);
    logic [2:0] n;
    n = KW_NONE;
    case (p)
      KW_F:    n = (c == "u") ? KW_FU   : KW_NONE;
      KW_FU:   n = (c == "n") ? KW_FUN  : KW_NONE;
      KW_FUN:  n = (c == "c") ? KW_FUNC : KW_NONE;
      KW_V:    n = (c == "a") ? KW_VA   : KW_NONE;
      KW_VA:   n = (c == "r") ? KW_VAR  : KW_NONE;
      default: n = KW_NONE;
    endcase
    return n;
  endfunction

  mode_t                  mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [OFFSET_BITS-1:0] cur_r, cur_nxt;
  logic [2:0]             kw_r, kw_nxt;

  logic [OFFSET_BITS-1:0]         diff;
  logic [OFFSET_BITS+LEN_W-1:0]   diff_ext;
  logic [OFFSET_BITS+START_W-1:0] start_ext;
  logic [OFFSET_BITS+START_W-1:0] cur_ext;
  logic [LEN_W-1:0]               tok_len;
  logic [START_W-1:0]             tok_start;
  logic [START_W-1:0]             cur_pos;

  logic  is_letter, is_digit;
  logic  punct_hit;
  kind_t punct_kind;
  kind_t flush_kind;
  logic  pending;
  logic  do_flush, do_new, classify;
  res_t  flush_res, new_res;

  assign diff      = cur_r - start_r;
  assign diff_ext  = {{LEN_W{1'b0}}, diff};
  assign start_ext = {{START_W{1'b0}}, start_r};
  assign cur_ext   = {{START_W{1'b0}}, cur_r};
  assign tok_len   = diff_ext[LEN_W-1:0];
  assign tok_start = start_ext[START_W-1:0];
  assign cur_pos   = cur_ext[START_W-1:0];

  assign is_letter = (byte_req >= "a" && byte_req <= "z") ||
                     (byte_req >= "A" && byte_req <= "Z") || byte_req == "_";
  assign is_digit  = byte_req >= "0" && byte_req <= "9";
  assign pending   = mode_r != MODE_IDLE;

  always_comb begin
    punct_hit  = 1'b1;
    punct_kind = K_EOF;
    case (byte_req)
      "(":     punct_kind = K_LPAREN;
      "{":     punct_kind = K_LBRACE;
      "[":     punct_kind = K_LBRACK;
      ")":     punct_kind = K_RPAREN;
      "}":     punct_kind = K_RBRACE;
      "]":     punct_kind = K_RBRACK;
      ".":     punct_kind = K_DOT;
      ",":     punct_kind = K_COMMA;
      ":":     punct_kind = K_COLON;
      ";":     punct_kind = K_SEMI;
      "=":     punct_kind = K_EQUAL;
      "@":     punct_kind = K_AT;
      "#":     punct_kind = K_HASH;
      "+":     punct_kind = K_BINOP;
      "*":     punct_kind = K_BINOP;
      default: punct_hit  = 1'b0;
    endcase
  end

  always_comb begin
    case (mode_r)
      MODE_IDENT:   flush_kind = (kw_r == KW_FUNC) ? K_FUNC :
                                 (kw_r == KW_VAR)  ? K_VAR  : K_IDENT;
      MODE_NUMBER:  flush_kind = K_INTEGER;
      MODE_COMMENT: flush_kind = K_COMMENT;
      default:      flush_kind = K_BINOP;
    endcase
  end

  always_comb begin
    mode_nxt  = mode_r;
    start_nxt = start_r;
    cur_nxt   = cur_r + OFFSET_BITS'(1);
    kw_nxt    = kw_r;
    do_flush  = 1'b0;
    do_new    = 1'b0;
    classify  = 1'b0;
    new_res   = '{kind: K_EOF, start: cur_pos, length: '0, last: 1'b1};

    if (end_of_buffer) begin
      do_flush  = pending;
      do_new    = 1'b1;
      mode_nxt  = MODE_IDLE;
      start_nxt = '0;
      cur_nxt   = '0;
      kw_nxt    = KW_NONE;
    end else begin
      case (mode_r)
        MODE_COMMENT: begin
          if (byte_req == "\n") begin
            do_flush = 1'b1;
            mode_nxt = MODE_IDLE;
            kw_nxt   = KW_NONE;
          end
        end
        MODE_IDENT: begin
          if (is_letter) begin
            kw_nxt = kw_next(kw_r, byte_req);
          end else begin
            do_flush = 1'b1;
            classify = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (!is_digit) begin
            do_flush = 1'b1;
            classify = 1'b1;
          end
        end
        MODE_MINUS: begin
          if (byte_req == ">") begin
            do_new   = 1'b1;
            new_res  = '{kind: K_ARROW, start: tok_start, length: LEN_W'(2), last: 1'b1};
            mode_nxt = MODE_IDLE;
          end else begin
            do_flush = 1'b1;
            classify = 1'b1;
          end
        end
        MODE_SLASH: begin
          if (byte_req == "/") begin
            mode_nxt = MODE_COMMENT;
          end else begin
            do_flush = 1'b1;
            classify = 1'b1;
          end
        end
        default: classify = 1'b1;
      endcase

      if (classify) begin
        mode_nxt  = MODE_IDLE;
        kw_nxt    = KW_NONE;
        start_nxt = cur_r;
        if (punct_hit) begin
          do_new  = 1'b1;
          new_res = '{kind: punct_kind, start: cur_pos, length: LEN_W'(1), last: 1'b1};
        end else if (byte_req == "-") begin
          mode_nxt = MODE_MINUS;
        end else if (byte_req == "/") begin
          mode_nxt = MODE_SLASH;
        end else if (is_letter) begin
          mode_nxt = MODE_IDENT;
          kw_nxt   = (byte_req == "f") ? KW_F : (byte_req == "v") ? KW_V : KW_NONE;
        end else if (is_digit) begin
          mode_nxt = MODE_NUMBER;
        end else if (byte_req == 8'h00) begin
          do_new  = 1'b1;
          new_res = '{kind: K_WARN, start: cur_pos, length: '0, last: 1'b1};
        end
      end
    end
  end

  assign flush_res = '{kind: flush_kind, start: tok_start, length: tok_len, last: !do_new};

  always_comb begin
    push.cnt = acc ? (2'(do_flush) + 2'(do_new)) : 2'd0;
    push.r0  = do_flush ? flush_res : new_res;
    push.r1  = new_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      start_r <= '0;
      cur_r   <= '0;
      kw_r    <= KW_NONE;
    end else if (acc) begin
      mode_r  <= mode_nxt;
      start_r <= start_nxt;
      cur_r   <= cur_nxt;
      kw_r    <= kw_nxt;
    end
  end

endmodule

// ----- rtl/core/tscan_rq.sv -----
// Token queue: takes up to two tokens per cycle, hands out one per cycle while popped.
module tscan_rq import tscan_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  input  logic  pop,
  output logic  space,
  output logic  head_valid,
  output res_t  head
);

  res_t             q_r [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RQ_CW-1:0] cnt_r, cnt_nxt;
  logic [RQ_AW-1:0] wr_ptr1;
  logic             do_pop;

  assign space      = cnt_r <= RQ_CW'(RQ_DEPTH - 2);
  assign head_valid = cnt_r != '0;
  assign head       = q_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;
  assign wr_ptr1    = wr_ptr_r + RQ_AW'(1);
  assign wr_ptr_nxt = wr_ptr_r + RQ_AW'(push.cnt);
  assign rd_ptr_nxt = rd_ptr_r + RQ_AW'(do_pop);
  assign cnt_nxt    = cnt_r + RQ_CW'(push.cnt) - RQ_CW'(do_pop);

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      q_r[wr_ptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      q_r[wr_ptr1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/core/token_scanner.sv -----
// Token scanner top level: streaming lexer with a request channel and a token channel.
// One source byte per request is taken every cycle while the four-entry token queue
// has room for two tokens; the byte is classified in the same cycle it is accepted
// and its tokens are written into the queue that drives the token channel. A request
// yields zero, one or two tokens (a closed pending token followed by the new byte's
// own token, or the flushed token followed by eof), and the token channel moves one
// token per cycle while out_req.ready is high, so two-token requests are limited by
// the output side. last_of_run marks the final token of each request. Offsets are
// OFFSET_BITS wide and wrap; an end-of-buffer request resets them to zero.
module token_scanner import tscan_pkg::*; #(
  parameter int OFFSET_BITS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  tscan_in_if.sink    in_req,
  tscan_out_if.source out_req
);

  push_t push;
  logic  acc;
  logic  space;
  logic  head_valid;
  res_t  head;

  assign in_req.ready = space;
  assign acc          = in_req.valid && space;

  tscan_lex #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_lex (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc           (acc),
    .byte_req      (in_req.byte_req),
    .end_of_buffer (in_req.end_of_buffer),
    .push          (push)
  );

  tscan_rq u_rq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (out_req.ready),
    .space      (space),
    .head_valid (head_valid),
    .head       (head)
  );

  assign out_req.valid        = head_valid;
  assign out_req.token_kind   = head.kind;
  assign out_req.token_start  = head.start;
  assign out_req.token_length = head.length;
  assign out_req.last_of_run  = head.last;

endmodule

// ----- rtl/core/tscan_chk.sv -----
// Port-level checker for the token scanner, bound to the top level.
module tscan_chk import tscan_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input kind_t              token_kind,
  input logic [START_W-1:0] token_start,
  input logic [LEN_W-1:0]   token_length,
  input logic               last_of_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(token_kind) &&
      $stable(token_start) && $stable(token_length) && $stable(last_of_run))
    else $error("token changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("token valid right after reset");

  a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (token_kind == K_EOF || token_kind == K_WARN) |->
      token_length == '0 && last_of_run)
    else $error("eof or warning with length or not last");

  a_punct_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && token_kind >= K_LPAREN && token_kind <= K_HASH |->
      token_length == LEN_W'(1) && last_of_run)
    else $error("punctuation token malformed");

endmodule

bind token_scanner tscan_chk u_tscan_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_req.valid),
  .out_ready    (out_req.ready),
  .token_kind   (out_req.token_kind),
  .token_start  (out_req.token_start),
  .token_length (out_req.token_length),
  .last_of_run  (out_req.last_of_run)
);
